[design/scbm_pkg.sv]
// scbm_pkg: shared types and constants for the sound cartridge bank mapper.
// No dependencies; imported by scbm_cart_mem, sound_cart_bank_mapper and the testbench.

package scbm_pkg;

    localparam int MAX_BANKS  = 16;
    localparam int OFFSET_W   = 13;
    localparam int BANK_W     = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int MEM_AW     = BANK_W + OFFSET_W;
    localparam int MEM_DEPTH  = MAX_BANKS * (2 ** OFFSET_W);

    localparam logic [8:0] MAX_BANKS_C = 9'(MAX_BANKS);

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_BANK_COUNT = 2'd0;
    localparam logic [1:0] REG_BANK_MASK  = 2'd1;
    localparam logic [1:0] REG_BANK_BASE  = 2'd2;

    localparam logic [8:0] RST_BANK_COUNT = 9'd16;
    localparam logic [7:0] RST_BANK_MASK  = 8'd15;
    localparam logic [7:0] RST_BANK_BASE  = 8'd0;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    // address decode constants
    localparam logic [14:0] MODE_ADDR_HI   = 15'h5FFF;  // 0xBFFE/0xBFFF >> 1
    localparam logic [4:0]  WIN_COMPAT_HI  = 5'h13;     // 0x9800-0x9FFF >> 11
    localparam logic [4:0]  WIN_PLUS_HI    = 5'h17;     // 0xB800-0xBFFF >> 11
    localparam logic [1:0]  BANK_SEL_BITS  = 2'b10;     // (addr & 0x1800) == 0x1000
    localparam logic [7:0]  UNMAPPED_BYTE  = 8'hFF;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    typedef struct packed {
        logic       from_mem;
        logic [7:0] rd;
        logic       cr;
        logic       cw;
        logic [7:0] co;
        logic [7:0] cd;
        logic       pm;
    } t_result;

endpackage

[design/scbm_cart_mem.sv]
// scbm_cart_mem: cartridge byte store, one write and one registered read per cycle.
// Depends on scbm_pkg for depth, address width and the request struct.

module scbm_cart_mem
    import scbm_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/sound_cart_bank_mapper.sv]
// sound_cart_bank_mapper: top level; bank and mode registers, decode, result pipeline.
// Depends on scbm_pkg and scbm_cart_mem.
// A request passes the memory read stage, then the output register, before its result
// is offered. Throughput: one request per cycle while m_axis_tready is high.
// Reset: bank registers 0,1,2,3, mode 0, config to defaults, pipeline emptied.
// Cartridge memory is not cleared; contents are undefined until written.

module sound_cart_bank_mapper
    import scbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
    input  logic [0:0]  s_axis_tuser,   // [0] op

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] read_data, [15:8] chip_offset,
                                        // [23:16] chip_data, [24] chip_plus_mode
    output logic [1:0]  m_axis_tuser,   // [0] chip_read, [1] chip_write

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0] r_bank_count;
    logic [7:0] r_bank_mask;
    logic [7:0] r_bank_base;
    logic [7:0] r_bank [4];
    logic [7:0] r_mode;

    logic       r_s1_vld;
    t_result    r_s1;
    logic       r_out_vld;
    t_result    r_out;

    logic       s_acc;
    logic       s1_adv;
    logic       cfg_wr;

    logic [15:0] a;
    logic [7:0]  d;
    logic        op;
    logic [1:0]  rgn;
    logic        in_win;
    logic        win_compat;
    logic        win_plus;
    logic        in_chip;
    logic        rgn_ram;
    logic [7:0]  bank_v;
    logic        mapped;
    logic        mode_wr;
    logic        bank_wr;
    logic [7:0]  n_mode;
    t_result     n_s1;
    t_mem_req    mem_req;
    logic [7:0]  mem_rdata;
    logic [7:0]  s1_rd;
    t_result     s1_res;

    // ---------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count <= RST_BANK_COUNT;
            r_bank_mask  <= RST_BANK_MASK;
            r_bank_base  <= RST_BANK_BASE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BANK_COUNT: r_bank_count <= pwdata[8:0];
                REG_BANK_MASK:  r_bank_mask  <= pwdata[7:0];
                REG_BANK_BASE:  r_bank_base  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BANK_COUNT: prdata = {23'd0, r_bank_count};
            REG_BANK_MASK:  prdata = {24'd0, r_bank_mask};
            REG_BANK_BASE:  prdata = {24'd0, r_bank_base};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- handshake
    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // ---------------- decode
    assign a   = s_axis_tdata[15:0];
    assign d   = s_axis_tdata[23:16];
    assign op  = s_axis_tuser[0];
    assign rgn = a[14:13] ^ 2'b10;

    assign in_win     = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
    assign win_plus   = r_mode[5] && r_bank[3][7];
    assign win_compat = !r_mode[5] && (r_bank[2][5:0] == 6'h3F);
    assign in_chip    = (win_compat && (a[15:11] == WIN_COMPAT_HI)) ||
                        (win_plus && (a[15:11] == WIN_PLUS_HI));

    always_comb begin
        case (rgn)
            2'd0:    rgn_ram = r_mode[4] || r_mode[0];
            2'd1:    rgn_ram = r_mode[4] || r_mode[1];
            2'd2:    rgn_ram = r_mode[4] || (r_mode[5] && r_mode[2]);
            default: rgn_ram = r_mode[4];
        endcase
    end

    assign bank_v = (r_bank[rgn] & r_bank_mask) - r_bank_base;
    assign mapped = ({1'b0, bank_v} < r_bank_count) && ({1'b0, bank_v} < MAX_BANKS_C);

    assign mode_wr = s_acc && (op == OP_WRITE) && in_win && (a[15:1] == MODE_ADDR_HI);
    assign bank_wr = s_acc && (op == OP_WRITE) && in_win && !mode_wr && !rgn_ram &&
                     (a[12:11] == BANK_SEL_BITS);
    assign n_mode  = mode_wr ? d : r_mode;

    always_comb begin
        mem_req.we    = s_acc && (op == OP_WRITE) && in_win && !mode_wr && rgn_ram && mapped;
        mem_req.re    = s_acc && (op == OP_READ) && !in_chip && in_win && mapped;
        mem_req.addr  = {bank_v[BANK_W-1:0], a[OFFSET_W-1:0]};
        mem_req.wdata = d;

        n_s1          = '0;
        n_s1.pm       = n_mode[5];
        if (op == OP_READ) begin
            if (in_chip) begin
                n_s1.cr = 1'b1;
                n_s1.co = a[7:0];
            end else if (in_win && mapped) begin
                n_s1.from_mem = 1'b1;
            end else begin
                n_s1.rd = UNMAPPED_BYTE;
            end
        end else if (in_win && !mode_wr && !rgn_ram && (a[12:11] != BANK_SEL_BITS) &&
                     in_chip) begin
            n_s1.cw = 1'b1;
            n_s1.co = a[7:0];
            n_s1.cd = d;
        end
    end

    // ---------------- state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 8'd0;
            r_bank[0] <= 8'd0;
            r_bank[1] <= 8'd1;
            r_bank[2] <= 8'd2;
            r_bank[3] <= 8'd3;
        end else begin
            r_mode <= n_mode;
            if (bank_wr) begin
                r_bank[rgn] <= d;
            end
        end
    end

    scbm_cart_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // ---------------- result pipeline
    assign s1_rd = r_s1.from_mem ? mem_rdata : r_s1.rd;

    always_comb begin
        s1_res    = r_s1;
        s1_res.rd = s1_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= s1_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out.pm, r_out.cd, r_out.co, r_out.rd};
    assign m_axis_tuser  = {r_out.cw, r_out.cr};

    // ---------------- assertions
    a_mem_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write in the same cycle");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_vld && r_out_vld))
        else $error("input stalled with a free pipeline slot");

    a_mem_read_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.re |=> (r_s1_vld && r_s1.from_mem))
        else $error("memory read issued without a stage to hold it");

    a_chip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> !(r_s1.cr && r_s1.cw) && !(r_s1.from_mem && (r_s1.cr || r_s1.cw)))
        else $error("conflicting result kinds");

    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_wr |=> (r_mode == $past(d)))
        else $error("mode register not updated");

endmodule

[tb/testbench.sv]
// Self-checking testbench for sound_cart_bank_mapper: streams bus accesses, predicts replies.
// Depends on scbm_pkg and the sound_cart_bank_mapper RTL; memory is preloaded through RAM writes.
`timescale 1ns / 100ps

module testbench
    import scbm_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 180;
    localparam logic [7:0] MODE_ROM     = 8'h00;
    localparam logic [7:0] MODE_ALL_RAM = 8'h10;
    localparam logic [7:0] MODE_PLUS    = 8'h20;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wd;
    } t_bus_access;

    typedef struct packed {
        logic [7:0] rd;
        logic       cr;
        logic       cw;
        logic [7:0] co;
        logic [7:0] cd;
        logic       pm;
    } t_bus_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [15:0] address, [23:16] write_data
    logic [0:0]  s_axis_tuser = '0;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [7:0] read_data, [15:8] chip_offset,
                                      // [23:16] chip_data, [24] chip_plus_mode
    logic [1:0]  m_axis_tuser;        // [0] chip_read, [1] chip_write
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sound_cart_bank_mapper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // mapper state as predicted
    logic [7:0] bank_reg [4];
    logic [7:0] mode;
    logic [7:0] cart_mem [MEM_DEPTH];
    logic [8:0] cfg_count;
    logic [7:0] cfg_mask;
    logic [7:0] cfg_base;

    t_bus_access access_queue[$];
    t_bus_reply  expected_replies[$];
    int          n_queued = 0;
    int          n_accepted = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    bit          steady_flow = 1'b0;
    logic        in_taken = 1'b0;

    always #6 i_clk = ~i_clk;

    function automatic bit window_hit(input logic [15:0] a);
        if (mode[5] && bank_reg[3][7])
            return a[15:11] == WIN_PLUS_HI;
        if (!mode[5] && bank_reg[2][5:0] == 6'h3F)
            return a[15:11] == WIN_COMPAT_HI;
        return 1'b0;
    endfunction

    function automatic bit ram_region(input logic [1:0] r);
        if (mode[4])
            return 1'b1;
        case (r)
            2'd0: return mode[0];
            2'd1: return mode[1];
            2'd2: return (mode & 8'h24) == 8'h24;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit lookup_bank(input logic [1:0] r, output int bank);
        logic [7:0] v;
        v = (bank_reg[r] & cfg_mask) - cfg_base;
        bank = int'(v);
        return ({1'b0, v} < cfg_count) && (int'(v) < MAX_BANKS);
    endfunction

    // offsets inside a bank that are preloaded and later reused
    function automatic logic [12:0] sample_offset(input logic [4:0] k);
        return {k[4:3], 3'b000, 8'(k[2:0]) * 8'h23};
    endfunction

    function automatic t_bus_reply predict_access(input t_bus_access acc);
        t_bus_reply rep;
        logic [1:0] r;
        int         bank;
        bit         in_span;
        rep = '0;
        r = 2'(acc.addr[15:13] - 3'd2);
        in_span = acc.addr >= 16'h4000 && acc.addr < 16'hC000;
        if (acc.op == OP_READ) begin
            if (window_hit(acc.addr)) begin
                rep.cr = 1'b1;
                rep.co = acc.addr[7:0];
            end else if (in_span && lookup_bank(r, bank)) begin
                rep.rd = cart_mem[bank * (2 ** OFFSET_W) + int'(acc.addr[12:0])];
            end else begin
                rep.rd = UNMAPPED_BYTE;
            end
        end else if (in_span) begin
            if (acc.addr[15:1] == MODE_ADDR_HI) begin
                mode = acc.wd;
            end else if (ram_region(r)) begin
                if (lookup_bank(r, bank))
                    cart_mem[bank * (2 ** OFFSET_W) + int'(acc.addr[12:0])] = acc.wd;
            end else if (acc.addr[12:11] == BANK_SEL_BITS) begin
                bank_reg[r] = acc.wd;
            end else if (window_hit(acc.addr)) begin
                rep.cw = 1'b1;
                rep.co = acc.addr[7:0];
                rep.cd = acc.wd;
            end
        end
        rep.pm = mode[5];
        return rep;
    endfunction

    function automatic t_bus_access random_access();
        t_bus_access acc;
        int          k;
        k = $urandom_range(99);
        acc.op = 1'($urandom_range(1));
        acc.addr = 16'($urandom);
        acc.wd = 8'($urandom);
        if (k < 8) begin
            acc.op = OP_WRITE;
            acc.addr = {MODE_ADDR_HI, 1'($urandom)};
        end else if (k < 20) begin
            // bank select writes, biased towards the values that open a chip window
            acc.op = OP_WRITE;
            acc.addr = {3'($urandom_range(5, 2)), BANK_SEL_BITS, 11'($urandom)};
            case ($urandom_range(3))
                0: acc.wd |= 8'h3F;
                1: acc.wd |= 8'h80;
                default: ;
            endcase
        end else if (k < 35) begin
            acc.addr = {($urandom_range(1) != 0) ? WIN_PLUS_HI : WIN_COMPAT_HI, 11'($urandom)};
        end else if (k < 75) begin
            acc.addr = {3'($urandom_range(5, 2)), 13'($urandom)};
            acc.op = ($urandom_range(9) < 6) ? OP_READ : OP_WRITE;
        end
        // in-span accesses keep to the preloaded offsets
        if (k >= 8 && acc.addr >= 16'h4000 && acc.addr < 16'hC000)
            acc.addr = {acc.addr[15:13], sample_offset({acc.addr[12:11], acc.addr[2:0]})};
        return acc;
    endfunction

    task automatic queue_access(input logic op, input logic [15:0] addr, input logic [7:0] wd);
        access_queue.push_back('{op: op, addr: addr, wd: wd});
        n_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_accepted != n_queued || expected_replies.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_BANK_COUNT: cfg_count = value[8:0];
            REG_BANK_MASK:  cfg_mask = value[7:0];
            REG_BANK_BASE:  cfg_base = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mapping(input int count, input int mask, input int base);
        write_reg(REG_BANK_COUNT, 32'(count));
        write_reg(REG_BANK_MASK, 32'(mask));
        write_reg(REG_BANK_BASE, 32'(base));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge i_clk)
        in_taken <= s_axis_tvalid && s_axis_tready;

    always @(negedge i_clk) begin : drive_requests
        t_bus_access acc;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (access_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 19)) begin
                acc = access_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {acc.wd, acc.addr};
                s_axis_tuser <= acc.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= steady_flow || $urandom_range(99) >= 19;

    always @(posedge i_clk) begin : observe
        t_bus_access acc;
        t_bus_reply  want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $error("reply with no request outstanding");
                end else begin
                    want = expected_replies.pop_front();
                    check_field("read_data", want.rd, m_axis_tdata[7:0]);
                    check_field("chip_read", want.cr, m_axis_tuser[0]);
                    check_field("chip_write", want.cw, m_axis_tuser[1]);
                    check_field("chip_offset", want.co, m_axis_tdata[15:8]);
                    check_field("chip_data", want.cd, m_axis_tdata[23:16]);
                    check_field("chip_plus_mode", want.pm, m_axis_tdata[24]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                acc = '{op: s_axis_tuser[0], addr: s_axis_tdata[15:0], wd: s_axis_tdata[23:16]};
                expected_replies.push_back(predict_access(acc));
                n_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int counts [8];
        int masks  [8];
        int bases  [8];
        counts = '{16, 256, 1, 17, 8, 0, 0, 16};
        masks  = '{15, 255, 0, 255, 7, 0, 0, 15};
        bases  = '{0, 255, 0, 0, 4, 0, 0, 0};
        bank_reg = '{8'd0, 8'd1, 8'd2, 8'd3};
        mode = '0;
        cfg_count = RST_BANK_COUNT;
        cfg_mask = RST_BANK_MASK;
        cfg_base = RST_BANK_BASE;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // preload the sampled offsets of every bank through region 0
        steady_flow = 1'b1;
        for (int b = 0; b < MAX_BANKS; b++) begin
            queue_access(OP_WRITE, 16'hBFFF, MODE_ROM);
            queue_access(OP_WRITE, 16'h5000, 8'(b));
            queue_access(OP_WRITE, 16'hBFFF, MODE_ALL_RAM);
            for (int k = 0; k < 32; k++)
                queue_access(OP_WRITE, {3'b010, sample_offset(5'(k))}, 8'($urandom));
        end
        wait_idle();
        steady_flow = 1'b0;

        queue_access(OP_WRITE, 16'hBFFF, MODE_ROM);
        queue_access(OP_READ, 16'h0000, 8'h00);
        queue_access(OP_READ, 16'hFFFF, 8'hFF);
        queue_access(OP_READ, 16'h3FFF, 8'h00);
        queue_access(OP_WRITE, 16'h0000, 8'hFF);
        queue_access(OP_WRITE, 16'hFFFF, 8'h00);
        queue_access(OP_WRITE, 16'hC000, 8'h5A);
        queue_access(OP_WRITE, 16'h9000, 8'h3F);
        queue_access(OP_READ, 16'h9800, 8'h00);
        queue_access(OP_WRITE, 16'h98FF, 8'hA5);
        queue_access(OP_READ, 16'h9FFF, 8'h00);
        queue_access(OP_WRITE, 16'hB000, 8'h80);
        queue_access(OP_WRITE, 16'hBFFE, MODE_PLUS);
        queue_access(OP_READ, 16'hB800, 8'h00);
        queue_access(OP_WRITE, 16'hBFFD, 8'h5A);
        queue_access(OP_READ, 16'h9800, 8'h00);
        queue_access(OP_WRITE, 16'hBFFF, 8'h34);
        queue_access(OP_WRITE, 16'hB900, 8'h11);
        queue_access(OP_READ, 16'hB900, 8'h00);
        queue_access(OP_READ, 16'h4000, 8'h00);
        queue_access(OP_READ, 16'hBFFF, 8'h00);
        wait_idle();

        // single bank present: region 1 is pushed out of range
        set_mapping(1, 255, 0);
        queue_access(OP_WRITE, 16'hBFFF, MODE_ROM);
        queue_access(OP_WRITE, 16'h5000, 8'h00);
        queue_access(OP_WRITE, 16'h7000, 8'h20);
        queue_access(OP_READ, 16'h6000, 8'h00);
        queue_access(OP_WRITE, 16'hBFFF, 8'h03);
        queue_access(OP_WRITE, 16'h6123, 8'h77);
        queue_access(OP_WRITE, 16'h4123, 8'h66);
        queue_access(OP_READ, 16'h4123, 8'h00);
        queue_access(OP_READ, 16'h7FFF, 8'h00);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            if (p == 5 || p == 6)
                set_mapping($urandom_range(256, 1), $urandom_range(255), $urandom_range(255));
            else
                set_mapping(counts[p], masks[p], bases[p]);
            steady_flow = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                access_queue.push_back(random_access());
            n_queued += PHASE_ITEMS;
            wait_idle();
        end
        steady_flow = 1'b0;
        repeat (8) @(negedge i_clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
